// ----- rtl/core/rmie_pkg.sv -----
// Shared types and constants for the register machine instruction executor.
`default_nettype none

package rmie_pkg;

  localparam int WORD_W        = 64;
  localparam int COST_TOTAL_W  = 63;
  localparam int COST_W        = 7;
  localparam int REG_COUNT     = 8;
  localparam int REG_W         = $clog2(REG_COUNT);
  localparam int ARG_W         = 12;
  localparam int ACTION_W      = 5;
  localparam int LEN_W         = 13;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int PC_W          = $clog2(PROGRAM_DEPTH);

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 208;

  localparam logic [LEN_W-1:0] PROGRAM_LENGTH_RESET = 13'd4096;

  localparam logic [COST_W-1:0] COST_NONE   = 7'd0;
  localparam logic [COST_W-1:0] COST_IO     = 7'd100;
  localparam logic [COST_W-1:0] COST_MEM    = 7'd50;
  localparam logic [COST_W-1:0] COST_ALU    = 7'd5;
  localparam logic [COST_W-1:0] COST_SIMPLE = 7'd1;

  localparam logic [COST_TOTAL_W-1:0] COST_LIMIT = {COST_TOTAL_W{1'b1}};

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_INSTR = 2'd1;
  localparam logic [1:0] FAULT_DATA  = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    OP_HALT   = 5'd0,
    OP_READ   = 5'd1,
    OP_WRITE  = 5'd2,
    OP_LOAD   = 5'd3,
    OP_STORE  = 5'd4,
    OP_RLOAD  = 5'd5,
    OP_RSTORE = 5'd6,
    OP_ADD    = 5'd7,
    OP_SUB    = 5'd8,
    OP_SWP    = 5'd9,
    OP_RST    = 5'd10,
    OP_INC    = 5'd11,
    OP_DEC    = 5'd12,
    OP_SHL    = 5'd13,
    OP_SHR    = 5'd14,
    OP_JUMP   = 5'd15,
    OP_JPOS   = 5'd16,
    OP_JZERO  = 5'd17,
    OP_CALL   = 5'd18,
    OP_RTRN   = 5'd19
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_HALT   = 2'd1,
    ST_IFAULT = 2'd2,
    ST_DFAULT = 2'd3
  } stop_t;

  function automatic logic [COST_TOTAL_W-1:0] sat_add(
    input logic [COST_TOTAL_W-1:0] total,
    input logic [COST_W-1:0]       cost
  );
    logic [COST_TOTAL_W-1:0] c;
    c = COST_TOTAL_W'(cost);
    return (total >= COST_LIMIT - c) ? COST_LIMIT : total + c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rmie_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rmie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/register_machine_instruction_executor.sv -----
// Top level: eight-register accumulator machine executing one instruction per transaction.
//
// Usage:
//   s_axis carries one instruction per transaction: action, argument and the
//   value that a read places in r0. m_axis returns one result per instruction:
//   next fetch address, write value (tuser flags a write), halt, fault code
//   and both saturating cost totals. cfg_we/cfg_wdata set program_length.
//   Pipeline: an accepted instruction is registered into the execute stage as
//   the data memory is read, and the execute stage registers the result.
//   Throughput: one instruction per cycle unless stalled. The execute cycle
//   forwards the register file and store data to the instruction entering
//   behind it, so a register-indirect load or store may follow any instruction
//   directly. Reset: registers, address, totals and stop state clear at once;
//   the data memory is then swept to zero, every address in turn, with s_axis_tready low.
//   Stall: while m_axis_tready is low the result holds; one more instruction
//   is taken into the execute stage, which then holds with s_axis_tready low.
`default_nettype none

module register_machine_instruction_executor #(
  parameter int DATA_DEPTH = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rmie_pkg::LEN_W-1:0]      cfg_wdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // action[4:0], argument[16:5], read_value[80:17], zero pad
  input  wire logic [rmie_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // next_address[11:0], write_value[75:12], halted[76], fault[78:77],
  // time_cost[141:79], io_cost[204:142], zero pad
  output logic      [rmie_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // write_valid[0]
  output logic      [0:0]                      m_axis_tuser
);

  localparam int DA_W = $clog2(DATA_DEPTH);
  localparam int W    = rmie_pkg::WORD_W;
  localparam int CT_W = rmie_pkg::COST_TOTAL_W;
  localparam int PC_W = rmie_pkg::PC_W;
  localparam int RW   = rmie_pkg::REG_W;

  logic            clearing;
  logic [DA_W-1:0] clr_addr;

  logic [rmie_pkg::LEN_W-1:0] program_length;

  logic [W-1:0]         regs [rmie_pkg::REG_COUNT];
  logic [W-1:0]         reg_next [rmie_pkg::REG_COUNT];
  logic [PC_W-1:0]      pc;
  logic [CT_W-1:0]      time_total;
  logic [CT_W-1:0]      io_total;
  rmie_pkg::stop_t      stop;

  logic                          x_valid;
  logic [rmie_pkg::ACTION_W-1:0] x_action;
  logic [rmie_pkg::ARG_W-1:0]    x_arg;
  logic [W-1:0]                  x_rv;
  logic [DA_W-1:0]               x_maddr;
  logic                          x_fwd;
  logic [W-1:0]                  x_fwd_data;

  logic                          out_valid;
  logic [PC_W-1:0]               out_next_address;
  logic                          out_wv;
  logic [W-1:0]                  out_wval;
  logic                          out_halted;
  logic [1:0]                    out_fault;
  logic [CT_W-1:0]               out_time;
  logic [CT_W-1:0]               out_io;

  logic [rmie_pkg::ACTION_W-1:0] in_action;
  logic [rmie_pkg::ARG_W-1:0]    in_arg;
  logic [W-1:0]                  in_rv;
  logic [W-1:0]                  in_addr_val;
  logic [DA_W-1:0]               in_maddr;
  logic                          in_is_load;
  logic                          accept;
  logic                          x_fire;

  logic [W-1:0]                  rdata;

  logic [RW-1:0]                 ri;
  logic [W-1:0]                  a;
  logic [W-1:0]                  b;
  logic [W-1:0]                  ld;
  logic [W-1:0]                  addr_val;
  logic                          bad_addr;
  logic [W-1:0]                  r0_n;
  logic [W-1:0]                  rx_n;
  logic                          r0_we;
  logic                          rx_we;
  logic                          st_we;
  logic                          go;
  logic                          commit;
  logic                          wv;
  logic [rmie_pkg::COST_W-1:0]   tc;
  logic [rmie_pkg::COST_W-1:0]   ic;
  logic [W-1:0]                  target;
  logic [rmie_pkg::LEN_W-1:0]    len;
  rmie_pkg::stop_t               stop_n;
  logic [PC_W-1:0]               pc_n;
  logic [CT_W-1:0]               time_n;
  logic [CT_W-1:0]               io_n;

  logic                          ram_we;
  logic [DA_W-1:0]               ram_waddr;
  logic [W-1:0]                  ram_wdata;

  assign in_action = s_axis_tdata[4:0];
  assign in_arg    = s_axis_tdata[16:5];
  assign in_rv     = s_axis_tdata[80:17];

  assign x_fire        = x_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!x_valid || x_fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // execute stage
  always_comb begin
    ri       = x_arg[RW-1:0];
    a        = regs[0];
    b        = regs[ri];
    ld       = x_fwd ? x_fwd_data : rdata;
    addr_val = (x_action == rmie_pkg::OP_LOAD || x_action == rmie_pkg::OP_STORE)
               ? W'(x_arg) : b;
    bad_addr = addr_val >= W'(DATA_DEPTH);
    r0_n     = a;
    rx_n     = b;
    r0_we    = 1'b0;
    rx_we    = 1'b0;
    st_we    = 1'b0;
    go       = 1'b0;
    wv       = 1'b0;
    tc       = rmie_pkg::COST_NONE;
    ic       = rmie_pkg::COST_NONE;
    target   = W'(pc) + W'(1);
    stop_n   = stop;
    if (stop == rmie_pkg::ST_RUN) begin
      unique case (x_action)
        rmie_pkg::OP_HALT: begin
          stop_n = rmie_pkg::ST_HALT;
        end
        rmie_pkg::OP_READ: begin
          r0_n = x_rv; r0_we = 1'b1; ic = rmie_pkg::COST_IO; go = 1'b1;
        end
        rmie_pkg::OP_WRITE: begin
          wv = 1'b1; ic = rmie_pkg::COST_IO; go = 1'b1;
        end
        rmie_pkg::OP_LOAD, rmie_pkg::OP_STORE, rmie_pkg::OP_RLOAD, rmie_pkg::OP_RSTORE: begin
          if (bad_addr) begin
            stop_n = rmie_pkg::ST_DFAULT;
          end else begin
            if (x_action == rmie_pkg::OP_LOAD || x_action == rmie_pkg::OP_RLOAD) begin
              r0_n  = ld;
              r0_we = 1'b1;
            end else begin
              st_we = 1'b1;
            end
            tc = rmie_pkg::COST_MEM;
            go = 1'b1;
          end
        end
        rmie_pkg::OP_ADD: begin
          r0_n = a + b; r0_we = 1'b1; tc = rmie_pkg::COST_ALU; go = 1'b1;
        end
        rmie_pkg::OP_SUB: begin
          r0_n  = ($signed(a) >= $signed(b)) ? a - b : '0;
          r0_we = 1'b1; tc = rmie_pkg::COST_ALU; go = 1'b1;
        end
        rmie_pkg::OP_SWP: begin
          r0_n = b; rx_n = a; r0_we = 1'b1; rx_we = 1'b1;
          tc = rmie_pkg::COST_ALU; go = 1'b1;
        end
        rmie_pkg::OP_RST: begin
          rx_n = '0; rx_we = 1'b1; tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_INC: begin
          rx_n = b + W'(1); rx_we = 1'b1; tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_DEC: begin
          if (!b[W-1] && b != '0) begin
            rx_n = b - W'(1);
          end
          rx_we = 1'b1; tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_SHL: begin
          rx_n = {b[W-2:0], 1'b0}; rx_we = 1'b1; tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_SHR: begin
          rx_n = {b[W-1], b[W-1:1]}; rx_we = 1'b1; tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_JUMP: begin
          target = W'(x_arg); tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_JPOS: begin
          if (!a[W-1] && a != '0) begin
            target = W'(x_arg);
          end
          tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_JZERO: begin
          if (a == '0) begin
            target = W'(x_arg);
          end
          tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_CALL: begin
          r0_n = W'(pc) + W'(1); r0_we = 1'b1; target = W'(x_arg);
          tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        rmie_pkg::OP_RTRN: begin
          target = a; tc = rmie_pkg::COST_SIMPLE; go = 1'b1;
        end
        default: begin
        end
      endcase
    end

    len = (program_length > rmie_pkg::LEN_W'(rmie_pkg::PROGRAM_DEPTH))
          ? rmie_pkg::LEN_W'(rmie_pkg::PROGRAM_DEPTH) : program_length;
    pc_n   = pc;
    time_n = time_total;
    io_n   = io_total;
    if (go) begin
      time_n = rmie_pkg::sat_add(time_total, tc);
      io_n   = rmie_pkg::sat_add(io_total, ic);
      if (target >= W'(len)) begin
        stop_n = rmie_pkg::ST_IFAULT;
      end else begin
        pc_n = target[PC_W-1:0];
      end
    end

    commit = x_fire && go;
    for (int i = 0; i < rmie_pkg::REG_COUNT; i++) begin
      if (commit && r0_we && i == 0) begin
        reg_next[i] = r0_n;
      end else if (commit && rx_we && RW'(i) == ri) begin
        reg_next[i] = rx_n;
      end else begin
        reg_next[i] = regs[i];
      end
    end
  end

  // issue: data memory address from the argument or from forwarded register values
  always_comb begin
    in_is_load  = (in_action == rmie_pkg::OP_LOAD || in_action == rmie_pkg::OP_RLOAD);
    in_addr_val = (in_action == rmie_pkg::OP_RLOAD || in_action == rmie_pkg::OP_RSTORE)
                  ? reg_next[in_arg[RW-1:0]] : W'(in_arg);
    in_maddr    = in_addr_val[DA_W-1:0];
  end

  assign ram_we    = clearing || (commit && st_we);
  assign ram_waddr = clearing ? clr_addr : x_maddr;
  assign ram_wdata = clearing ? '0 : a;

  rmie_ram #(
    .WIDTH (W),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_maddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + DA_W'(1);
      if (clr_addr == DA_W'(DATA_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= rmie_pkg::PROGRAM_LENGTH_RESET;
    end else if (cfg_we) begin
      program_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rmie_pkg::REG_COUNT; i++) begin
        regs[i] <= '0;
      end
      pc         <= '0;
      time_total <= '0;
      io_total   <= '0;
      stop       <= rmie_pkg::ST_RUN;
    end else begin
      regs <= reg_next;
      if (x_fire) begin
        pc         <= pc_n;
        time_total <= time_n;
        io_total   <= io_n;
        stop       <= stop_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (accept) begin
      x_valid <= 1'b1;
    end else if (x_fire) begin
      x_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_action   <= in_action;
      x_arg      <= in_arg;
      x_rv       <= in_rv;
      x_maddr    <= in_maddr;
      x_fwd      <= commit && st_we && in_is_load && (x_maddr == in_maddr);
      x_fwd_data <= a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (x_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire) begin
      out_next_address <= pc_n;
      out_wv           <= wv;
      out_wval         <= wv ? a : '0;
      out_halted       <= (stop_n == rmie_pkg::ST_HALT);
      out_fault        <= (stop_n == rmie_pkg::ST_IFAULT) ? rmie_pkg::FAULT_INSTR :
                          (stop_n == rmie_pkg::ST_DFAULT) ? rmie_pkg::FAULT_DATA  :
                                                            rmie_pkg::FAULT_NONE;
      out_time         <= time_n;
      out_io           <= io_n;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_wv;
  assign m_axis_tdata  = {3'b000, out_io, out_time, out_fault, out_halted, out_wval,
                          out_next_address};

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("instruction accepted during memory clear");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stop != rmie_pkg::ST_RUN |=> stop == $past(stop))
    else $error("stop state changed after halt or fault");

  a_fwd_only_loads: assert property (@(posedge clk) disable iff (rst)
    x_valid && x_fwd |-> (x_action == rmie_pkg::OP_LOAD || x_action == rmie_pkg::OP_RLOAD))
    else $error("store data forwarded to a non-load");

  a_exec_after_clear: assert property (@(posedge clk) disable iff (rst)
    x_valid |-> !clearing)
    else $error("execute stage busy during memory clear");
`endif

endmodule

`default_nettype wire
